// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/lbfb_pkg.sv -----
// Package: constants, action codes and shared types of the bit field buffer.
package lbfb_pkg;

  localparam int STORE_BYTES     = 4096;
  localparam int ADDR_W          = $clog2(STORE_BYTES);
  localparam int CURSOR_W        = 13;
  localparam int CAP_W           = 13;
  localparam int LEN_W           = 6;
  localparam int DATA_W          = 32;
  localparam int POS_W           = 16;
  localparam int MAX_FIELD_BITS  = 32;
  localparam int MAX_FIELD_BYTES = MAX_FIELD_BITS / 8;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

  localparam logic [1:0] ACT_RD_BITS  = 2'd0;
  localparam logic [1:0] ACT_WR_BITS  = 2'd1;
  localparam logic [1:0] ACT_RD_BYTES = 2'd2;
  localparam logic [1:0] ACT_WR_BYTES = 2'd3;

  // word index of the capacity register (byte address 0)
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ----- sv/lbfb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lbfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/lbfb_byte_unit.sv -----
// Shared byte unit: extracts or replaces a run of bits within one store byte.
module lbfb_byte_unit (
  input  logic [7:0] rd_byte,
  input  logic [2:0] off,
  input  logic [3:0] take,
  input  logic [7:0] part,
  output logic [7:0] new_byte,
  output logic [7:0] got_bits
);

  logic [8:0] low_mask;
  logic [7:0] fmask;

  always_comb begin
    low_mask = (9'd1 << take) - 9'd1;
    fmask    = low_mask[7:0] << off;
    new_byte = (rd_byte & ~fmask) | ((part & low_mask[7:0]) << off);
    got_bits = (rd_byte & fmask) >> off;
  end

endmodule

// ----- sv/lbfb_seq.sv -----
// Sequencer: clearing pass, capacity check and byte-by-byte field transfer.
module lbfb_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lbfb_pkg::CAP_W-1:0]   cap_use,
  input  logic [1:0]                   action,
  input  logic [lbfb_pkg::LEN_W-1:0]   length,
  input  logic [lbfb_pkg::DATA_W-1:0]  write_value,
  input  logic                         in_valid,
  output logic                         in_stall,
  output logic [lbfb_pkg::DATA_W-1:0]  read_value,
  output logic                         overflow,
  output logic [lbfb_pkg::POS_W-1:0]   bit_position,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lbfb_pkg::ram_req_t           ram_req,
  input  logic [7:0]                   ram_rdata
);

  import lbfb_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CHECK, S_XFER, S_DONE} state_t;

  state_t              state;
  logic [ADDR_W-1:0]   clr_addr;
  logic [1:0]          action_q;
  logic [LEN_W-1:0]    len_q;
  logic [DATA_W-1:0]   wval;
  logic [CURSOR_W-1:0] cursor;
  logic [2:0]          off;
  logic [LEN_W-1:0]    remain;
  logic [LEN_W-1:0]    done_bits;
  logic [DATA_W-1:0]   acc;
  logic                ovf;

  logic                is_write;
  logic                is_byte;
  logic [LEN_W-1:0]    len_bits_c;
  logic [2:0]          len_bytes_c;
  logic [LEN_W-1:0]    len_bits;
  logic [CURSOR_W:0]   aligned;
  logic [16:0]         need_bits;
  logic [16:0]         cap_bits;
  logic [CURSOR_W+1:0] need_bytes;
  logic                fail;
  logic [CURSOR_W-1:0] start_cursor;
  logic [3:0]          room;
  logic [3:0]          take;
  logic [3:0]          off_sum;
  logic [CURSOR_W-1:0] cursor_next;
  logic [2:0]          off_next;
  logic [DATA_W-1:0]   wsh;
  logic [7:0]          new_byte;
  logic [7:0]          got_bits;
  logic                out_free;

  lbfb_byte_unit u_byte (
    .rd_byte  (ram_rdata),
    .off      (off),
    .take     (take),
    .part     (wsh[7:0]),
    .new_byte (new_byte),
    .got_bits (got_bits)
  );

  always_comb begin
    is_write    = action_q inside {ACT_WR_BITS, ACT_WR_BYTES};
    is_byte     = action_q inside {ACT_RD_BYTES, ACT_WR_BYTES};
    len_bits_c  = (len_q > LEN_W'(MAX_FIELD_BITS)) ? LEN_W'(MAX_FIELD_BITS) : len_q;
    len_bytes_c = (len_q > LEN_W'(MAX_FIELD_BYTES)) ? 3'(MAX_FIELD_BYTES) : len_q[2:0];
    len_bits    = is_byte ? {len_bytes_c, 3'b000} : len_bits_c;
    aligned     = {1'b0, cursor} + (CURSOR_W+1)'(off != 3'd0);
    need_bits   = {1'b0, cursor, off} + 17'(len_bits_c);
    cap_bits    = {1'b0, cap_use, 3'b000};
    need_bytes  = {1'b0, aligned} + (CURSOR_W+2)'(len_bytes_c);
    fail        = is_byte ? (need_bytes > (CURSOR_W+2)'(cap_use)) : (need_bits > cap_bits);
    start_cursor = is_byte ? aligned[CURSOR_W-1:0] : cursor;

    room    = 4'd8 - {1'b0, off};
    take    = (remain < LEN_W'(room)) ? remain[3:0] : room;
    off_sum = {1'b0, off} + take;
    if (off_sum[3]) begin
      cursor_next = cursor + CURSOR_W'(1);
      off_next    = 3'd0;
    end else begin
      cursor_next = cursor;
      off_next    = off_sum[2:0];
    end
    wsh = wval >> done_bits;

    out_free = !out_valid || !out_stall;
    in_stall = (state != S_IDLE);

    ram_req.we    = 1'b0;
    ram_req.waddr = cursor[ADDR_W-1:0];
    ram_req.wdata = new_byte;
    ram_req.raddr = cursor[ADDR_W-1:0];
    case (state)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        ram_req.wdata = 8'd0;
      end
      S_CHECK: begin
        ram_req.raddr = start_cursor[ADDR_W-1:0];
      end
      S_XFER: begin
        ram_req.we    = is_write;
        ram_req.raddr = cursor_next[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      cursor    <= '0;
      off       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            action_q <= action;
            len_q    <= length;
            wval     <= write_value;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          acc       <= '0;
          done_bits <= '0;
          remain    <= len_bits;
          ovf       <= fail;
          if (fail) begin
            state <= S_DONE;
          end else begin
            cursor <= start_cursor;
            if (is_byte) begin
              off <= 3'd0;
            end
            state <= (len_bits == '0) ? S_DONE : S_XFER;
          end
        end
        S_XFER: begin
          acc       <= acc | ({24'd0, got_bits} << done_bits);
          done_bits <= done_bits + LEN_W'(take);
          remain    <= remain - LEN_W'(take);
          cursor    <= cursor_next;
          off       <= off_next;
          if (remain == LEN_W'(take)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            read_value   <= is_write ? '0 : acc;
            overflow     <= ovf;
            bit_position <= {cursor, off};
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/lsb_first_bit_field_buffer_core.sv -----
// Top level: LSB-first bit field buffer with APB capacity register.
// After reset the 4096-byte store is cleared one byte per cycle, and the
// block stalls its input while it clears. Each accepted item then goes
// through the capacity check, one transfer step per store byte the field
// touches (0 to 5) through the byte-wide RAM and byte unit, a step to load
// the result and a return to idle, where the next item is accepted; the
// input stalls until then. The result sits in an output register; a stalled
// result holds the next item in the load step until the register is free.
module lsb_first_bit_field_buffer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbfb_pkg::PADDR_W-1:0]  paddr,
  input  logic [lbfb_pkg::PDATA_W-1:0]  pwdata,
  output logic [lbfb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic [1:0]                    action,
  input  logic [lbfb_pkg::LEN_W-1:0]    length,
  input  logic [lbfb_pkg::DATA_W-1:0]   write_value,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic [lbfb_pkg::DATA_W-1:0]   read_value,
  output logic                          overflow,
  output logic [lbfb_pkg::POS_W-1:0]    bit_position,
  output logic                          out_valid,
  input  logic                          out_stall
);

  import lbfb_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] cap_use;
  ram_req_t         ram_req;
  logic [7:0]       ram_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata  = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity) : '0;
    cap_use = (capacity > CAP_W'(STORE_BYTES)) ? CAP_W'(STORE_BYTES) : capacity;
  end

  lbfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  lbfb_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cap_use      (cap_use),
    .action       (action),
    .length       (length),
    .write_value  (write_value),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .read_value   (read_value),
    .overflow     (overflow),
    .bit_position (bit_position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata)
  );

endmodule

// ----- sv/lbfb_checker.sv -----
// Port-level checker for the bit field buffer, bound to the top level.
`include "assert_macros.svh"

module lbfb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [lbfb_pkg::DATA_W-1:0]   read_value,
  input logic                          overflow,
  input logic [lbfb_pkg::POS_W-1:0]    bit_position,
  input logic                          out_valid,
  input logic                          out_stall
);

  import lbfb_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(read_value) && $stable(bit_position) && $stable(overflow))
  `ASSERT_IMPLIES(a_ovf_zero, clk, rst, out_valid && overflow, read_value == '0)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_IMPLIES(a_pos_range, clk, rst, out_valid, bit_position <= POS_W'(STORE_BYTES * 8))

endmodule

bind lsb_first_bit_field_buffer_core lbfb_checker u_lbfb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .read_value   (read_value),
  .overflow     (overflow),
  .bit_position (bit_position),
  .out_valid    (out_valid),
  .out_stall    (out_stall)
);

// ----- dv/tb.sv -----
// Testbench for the LSB-first bit field buffer: random and directed field accesses, self-checked.
`timescale 1ns / 1ps

module tb;
  import lbfb_pkg::*;

  typedef struct packed {
    logic [1:0]        act;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] wval;
  } field_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] rval;
    logic              ovf;
    logic [POS_W-1:0]  pos;
  } field_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic [1:0]         action = ACT_RD_BITS;
  logic [LEN_W-1:0]   length = '0;
  logic [DATA_W-1:0]  write_value = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [DATA_W-1:0]  read_value;
  logic               overflow;
  logic [POS_W-1:0]   bit_position;
  logic               out_valid;
  logic               out_stall = 1'b0;

  field_req_t field_reqs_q[$];
  field_res_t expected_results_q[$];

  logic [7:0]          shadow_bytes [STORE_BYTES] = '{default: 8'h00};
  logic [CURSOR_W-1:0] shadow_cursor = '0;
  logic [2:0]          shadow_offset = '0;
  logic [CAP_W-1:0]    shadow_capacity = CAP_RESET;

  int  mismatch_count = 0;
  bit  calm = 1'b0;
  int  hold_asked = 0;
  int  hold_given = 0;
  int  hold_left = 0;

  lsb_first_bit_field_buffer_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .action       (action),
    .length       (length),
    .write_value  (write_value),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .read_value   (read_value),
    .overflow     (overflow),
    .bit_position (bit_position),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // updates the shadow store and cursor, returns the expected result
  function automatic field_res_t access_buffer(field_req_t req);
    field_res_t  res;
    int unsigned cap;
    int unsigned nbits;
    int unsigned aligned;
    int unsigned nbytes;
    logic        writing;
    logic        go;
    res = '0;
    go = 1'b0;
    nbits = 0;
    cap = (shadow_capacity > STORE_BYTES) ? STORE_BYTES : shadow_capacity;
    writing = (req.act == ACT_WR_BITS) || (req.act == ACT_WR_BYTES);
    if (req.act == ACT_RD_BITS || req.act == ACT_WR_BITS) begin
      nbits = (req.len > MAX_FIELD_BITS) ? MAX_FIELD_BITS : req.len;
      if (shadow_cursor * 8 + shadow_offset + nbits > cap * 8) begin
        res.ovf = 1'b1;
      end else begin
        go = 1'b1;
      end
    end else begin
      aligned = shadow_cursor + (shadow_offset != 0);
      nbytes = (req.len > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : req.len;
      if (aligned + nbytes > cap) begin
        res.ovf = 1'b1;
      end else begin
        go = 1'b1;
        shadow_cursor = CURSOR_W'(aligned);
        shadow_offset = '0;
        nbits = nbytes * 8;
      end
    end
    if (go) begin
      for (int i = 0; i < nbits; i++) begin
        if (writing) begin
          shadow_bytes[shadow_cursor[ADDR_W-1:0]][shadow_offset] = req.wval[i];
        end else begin
          res.rval[i] = shadow_bytes[shadow_cursor[ADDR_W-1:0]][shadow_offset];
        end
        shadow_offset = shadow_offset + 3'd1;
        if (shadow_offset == 3'd0) begin
          shadow_cursor = shadow_cursor + 1'b1;
        end
      end
    end
    if (writing) begin
      res.rval = '0;
    end
    res.pos = POS_W'(shadow_cursor * 8 + shadow_offset);
    return res;
  endfunction

  function automatic field_req_t random_request();
    field_req_t  req;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      req.act = ACT_WR_BITS;
    end else if (pick < 65) begin
      req.act = ACT_RD_BITS;
    end else if (pick < 85) begin
      req.act = ACT_WR_BYTES;
    end else begin
      req.act = ACT_RD_BYTES;
    end
    req.wval = $urandom();
    pick = $urandom_range(99);
    if (req.act == ACT_RD_BITS || req.act == ACT_WR_BITS) begin
      if (pick < 5) begin
        req.len = '0;
      end else if (pick < 60) begin
        req.len = LEN_W'($urandom_range(1, 8));
      end else if (pick < 88) begin
        req.len = LEN_W'($urandom_range(9, 32));
      end else begin
        req.len = LEN_W'($urandom_range(33, 63));
      end
    end else begin
      if (pick < 8) begin
        req.len = '0;
      end else if (pick < 88) begin
        req.len = LEN_W'($urandom_range(1, MAX_FIELD_BYTES));
      end else begin
        req.len = LEN_W'($urandom_range(MAX_FIELD_BYTES + 1, 63));
      end
    end
    return req;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results_q.push_back(access_buffer({action, length, write_value}));
      end
      if (!in_valid || !in_stall) begin
        if (field_reqs_q.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
          action      <= field_reqs_q[0].act;
          length      <= field_reqs_q[0].len;
          write_value <= field_reqs_q[0].wval;
          in_valid    <= 1'b1;
          void'(field_reqs_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      hold_given <= hold_given + 1;
      hold_left  <= 400;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 33);
    end
  end

  // result checker
  always @(posedge clk) begin
    field_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results_q.size() == 0) begin
        $display("%0t: unexpected result: read_value %h overflow %b bit_position %0d",
                 $time, read_value, overflow, bit_position);
        mismatch_count++;
      end else begin
        want = expected_results_q.pop_front();
        if (read_value !== want.rval) begin
          $display("%0t: read_value expected %h actual %h", $time, want.rval, read_value);
          mismatch_count++;
        end
        if (overflow !== want.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, want.ovf, overflow);
          mismatch_count++;
        end
        if (bit_position !== want.pos) begin
          $display("%0t: bit_position expected %0d actual %0d", $time, want.pos, bit_position);
          mismatch_count++;
        end
      end
    end
  end

  task automatic set_capacity(input int unsigned bytes);
    logic [PDATA_W-1:0] word;
    word = $urandom();
    word[CAP_W-1:0] = CAP_W'(bytes);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_CAPACITY, 2'b00});
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_capacity = CAP_W'(bytes);
  endtask

  task automatic offer(input logic [1:0] act, input int unsigned len, input logic [31:0] val);
    field_req_t req;
    req.act  = act;
    req.len  = LEN_W'(len);
    req.wval = val;
    field_reqs_q.push_back(req);
  endtask

  task automatic offer_random(input int count);
    @(negedge clk);
    repeat (count) field_reqs_q.push_back(random_request());
  endtask

  task automatic settle();
    @(negedge clk);
    while (field_reqs_q.size() != 0 || in_valid || expected_results_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (12) @(negedge clk);
  endtask

  function automatic int unsigned near_cursor(input int unsigned extra);
    int unsigned c;
    c = shadow_cursor + extra;
    return (c > STORE_BYTES) ? STORE_BYTES : c;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // capacity beyond the store acts as the store size
    set_capacity(8191);
    @(negedge clk);
    offer(ACT_RD_BITS,  1,  32'h0000_0000);
    offer(ACT_WR_BITS,  1,  32'hFFFF_FFFF);
    offer(ACT_WR_BITS,  0,  32'hFFFF_FFFF);
    offer(ACT_RD_BITS,  0,  32'h0000_0000);
    offer(ACT_WR_BITS,  32, 32'hFFFF_FFFF);
    offer(ACT_WR_BITS,  63, 32'hA5A5_5A5A);
    offer(ACT_RD_BITS,  32, 32'hFFFF_FFFF);
    offer(ACT_RD_BITS,  33, 32'h1234_5678);
    offer(ACT_WR_BITS,  7,  32'h0000_0055);
    offer(ACT_WR_BYTES, 0,  32'h0000_0000);
    offer(ACT_WR_BYTES, 1,  32'h0000_00C3);
    offer(ACT_WR_BITS,  3,  32'h0000_0005);
    offer(ACT_WR_BYTES, 4,  32'h0000_0000);
    offer(ACT_RD_BYTES, 4,  32'hFFFF_FFFF);
    offer(ACT_WR_BYTES, 5,  32'hDEAD_BEEF);
    offer(ACT_RD_BITS,  5,  32'h0000_0000);
    offer(ACT_RD_BYTES, 63, 32'h0000_0000);
    offer(ACT_WR_BYTES, 2,  32'hFFFF_FFFF);
    offer(ACT_RD_BYTES, 0,  32'h0000_0000);
    offer(ACT_WR_BITS,  31, 32'h8000_0000);
    offer(ACT_WR_BITS,  17, 32'h0001_FFFF);
    offer(ACT_RD_BYTES, 1,  32'h0000_0000);
    settle();

    calm = 1'b1;
    offer_random(300);
    settle();
    calm = 1'b0;

    // capacity just above the cursor: overflows near the boundary
    set_capacity(near_cursor($urandom_range(1, 8)));
    offer_random(120);
    settle();

    // capacity at or below the cursor: every field of nonzero length overflows
    set_capacity(0);
    offer_random(20);
    settle();
    set_capacity(shadow_cursor > 0 ? shadow_cursor - 1 : 0);
    offer_random(10);
    settle();

    set_capacity(STORE_BYTES);
    offer_random(320);
    hold_asked++;
    settle();

    set_capacity(near_cursor($urandom_range(0, 4)));
    offer_random(100);
    settle();

    set_capacity(STORE_BYTES);
    offer_random(320);
    hold_asked++;
    settle();

    if (mismatch_count == 0 && expected_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
